[design/sspe_pkg.sv]
// Shared types, constants and segment tables of the seven-segment panel encoder.
package sspe_pkg;

  localparam int unsigned TEMP_W    = 14;
  localparam int unsigned TIME_W    = 19;
  localparam int unsigned ADDR_W    = 6;
  localparam int unsigned NUM_BYTES = 20;
  localparam int unsigned CNT_W     = $clog2(NUM_BYTES);

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(NUM_BYTES - 1);

  localparam logic [7:0] DASH_PATTERN = 8'h08;
  localparam logic [7:0] HIGH_BIT     = 8'h80;
  localparam logic [7:0] LOW_BIT      = 8'h01;

  localparam logic [TIME_W-1:0] HM_LIMIT = TIME_W'(3599);
  localparam logic [TIME_W-1:0] MS_LIMIT = TIME_W'(59);

  // Byte i of the frame sits at index i.
  typedef logic [NUM_BYTES-1:0][7:0] frame_t;

  typedef struct packed {
    logic   valid;
    frame_t bytes;
  } frame_xfer_t;

  // Actual panel digits.
  function automatic logic [7:0] seg_act(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h77;
      4'd1:    s = 8'h24;
      4'd2:    s = 8'h5D;
      4'd3:    s = 8'h6D;
      4'd4:    s = 8'h2E;
      4'd5:    s = 8'h6B;
      4'd6:    s = 8'h7B;
      4'd7:    s = 8'h25;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // Set panel time digits.
  function automatic logic [7:0] seg_time(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h77;
      4'd1:    s = 8'h12;
      4'd2:    s = 8'h5D;
      4'd3:    s = 8'h5B;
      4'd4:    s = 8'h3A;
      4'd5:    s = 8'h6B;
      4'd6:    s = 8'h6F;
      4'd7:    s = 8'h52;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h7B;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // Set panel temperature digits.
  function automatic logic [7:0] seg_set(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hEE;
      4'd1:    s = 8'h24;
      4'd2:    s = 8'hBA;
      4'd3:    s = 8'hB6;
      4'd4:    s = 8'h74;
      4'd5:    s = 8'hD6;
      4'd6:    s = 8'hDE;
      4'd7:    s = 8'hA4;
      4'd8:    s = 8'hFE;
      4'd9:    s = 8'hF6;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

[design/sspe_pipe.sv]
// Four-stage digit pipeline: constant division, digit split, segment lookup, frame assembly.
module sspe_pipe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sspe_pkg::TEMP_W-1:0]   actual_temp_i,
  input  logic [sspe_pkg::TEMP_W-1:0]   set_temp_i,
  input  logic [sspe_pkg::TIME_W-1:0]   actual_time_i,
  input  logic [sspe_pkg::TIME_W-1:0]   set_time_i,
  input  logic                          beep_flash_i,
  input  logic                          heat_icon_on_i,
  input  logic                          time_icon_on_i,
  input  logic                          temp_blank_i,
  input  logic                          time_blank_i,
  output sspe_pkg::frame_xfer_t         frame_o,
  input  logic                          frame_ready_i
);

  // Exact reciprocals: floor(v * M / 2^K) equals v / D over the whole input range.
  localparam logic [20:0] M60   = 21'd1118482;
  localparam int unsigned K60   = 26;
  localparam logic [19:0] M3600 = 20'd596524;
  localparam int unsigned K3600 = 31;
  localparam logic [14:0] M10   = 15'd26215;
  localparam int unsigned K10   = 18;
  localparam logic [14:0] M100  = 15'd20972;
  localparam int unsigned K100  = 21;
  localparam logic [14:0] M1000 = 15'd16778;
  localparam int unsigned K1000 = 24;
  localparam logic [7:0]  M10S  = 8'd205;
  localparam int unsigned K10S  = 11;

  typedef struct packed {
    logic [13:0] at;
    logic [13:0] st;
    logic [10:0] at10;
    logic [10:0] st10;
    logic [7:0]  at100;
    logic [7:0]  st100;
    logic [4:0]  at1000;
    logic [4:0]  st1000;
    logic [18:0] atime;
    logic [18:0] stime;
    logic [13:0] aq60;
    logic [13:0] sq60;
    logic [7:0]  aq3600;
    logic [7:0]  sq3600;
    logic        hm;
    logic        ms;
    logic        st_zero;
    logic        show_atime;
    logic        heat;
    logic        ticon;
    logic        tblank;
    logic        mblank;
  } s1_t;

  typedef struct packed {
    logic [3:0][3:0] ad;
    logic [3:0][3:0] sd;
    logic            a_show0;
    logic            a_show1;
    logic            s_show0;
    logic            s_show1;
    logic [13:0]     ahi;
    logic [13:0]     shi;
    logic [5:0]      alo;
    logic [5:0]      slo;
    logic            hm;
    logic            st_zero;
    logic            show_atime;
    logic            heat;
    logic            ticon;
    logic            tblank;
    logic            mblank;
  } s2_t;

  typedef struct packed {
    logic [7:0][7:0] tb;
    logic [13:0]     ahi;
    logic [13:0]     shi;
    logic [10:0]     ahi10;
    logic [10:0]     shi10;
    logic [5:0]      alo;
    logic [5:0]      slo;
    logic [2:0]      alo10;
    logic [2:0]      slo10;
    logic            hm;
    logic            st_zero;
    logic            show_atime;
    logic            ticon;
    logic            mblank;
  } s3_t;

  // Four decimal digits of a temperature, from its exact quotients by 10, 100 and 1000.
  function automatic logic [3:0][3:0] temp_digits(input logic [13:0] t,
                                                  input logic [10:0] q10,
                                                  input logic [7:0]  q100,
                                                  input logic [4:0]  q1000);
    logic [3:0][3:0] d;
    logic [13:0]     r3;
    logic [10:0]     r2;
    logic [7:0]      r1;
    logic [4:0]      r0;
    r3 = t - 14'(q10) * 14'd10;
    r2 = q10 - 11'(q100) * 11'd10;
    r1 = q100 - 8'(q1000) * 8'd10;
    r0 = (q1000 >= 5'd10) ? (q1000 - 5'd10) : q1000;
    d[0] = r0[3:0];
    d[1] = r1[3:0];
    d[2] = r2[3:0];
    d[3] = r3[3:0];
    return d;
  endfunction

  // Time digits; the leading digit saturates at nine.
  function automatic logic [3:0][3:0] time_digits(input logic [13:0] hi,
                                                  input logic [10:0] hi10,
                                                  input logic [5:0]  lo,
                                                  input logic [2:0]  lo10);
    logic [3:0][3:0] d;
    logic [13:0]     hr;
    logic [5:0]      lr;
    hr = hi - 14'(hi10) * 14'd10;
    lr = lo - 6'(lo10) * 6'd10;
    d[0] = (hi10 > 11'd9) ? 4'd9 : hi10[3:0];
    d[1] = hr[3:0];
    d[2] = {1'b0, lo10};
    d[3] = lr[3:0];
    return d;
  endfunction

  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  sspe_pkg::frame_t f4_d, f4_q;

  logic [39:0] aprod60, sprod60;
  logic [38:0] aprod3600, sprod3600;
  logic [28:0] apr10, spr10, apr100, spr100, apr1000, spr1000;
  logic [18:0] asec, ssec;
  logic [13:0] amin, smin;
  logic [28:0] ahprod, shprod;
  logic [13:0] alprod, slprod;
  logic [3:0][3:0] atd, std_d;
  logic [7:0][7:0] tb;

  assign en4        = !v4_q || frame_ready_i;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  // Stage 1: quotients by constants and time format flags.
  always_comb begin
    aprod60   = 40'(actual_time_i) * 40'(M60);
    sprod60   = 40'(set_time_i) * 40'(M60);
    aprod3600 = 39'(actual_time_i) * 39'(M3600);
    sprod3600 = 39'(set_time_i) * 39'(M3600);
    apr10     = 29'(actual_temp_i) * 29'(M10);
    spr10     = 29'(set_temp_i) * 29'(M10);
    apr100    = 29'(actual_temp_i) * 29'(M100);
    spr100    = 29'(set_temp_i) * 29'(M100);
    apr1000   = 29'(actual_temp_i) * 29'(M1000);
    spr1000   = 29'(set_temp_i) * 29'(M1000);

    s1_d.at         = actual_temp_i;
    s1_d.st         = set_temp_i;
    s1_d.at10       = apr10[K10+10:K10];
    s1_d.st10       = spr10[K10+10:K10];
    s1_d.at100      = apr100[K100+7:K100];
    s1_d.st100      = spr100[K100+7:K100];
    s1_d.at1000     = apr1000[K1000+4:K1000];
    s1_d.st1000     = spr1000[K1000+4:K1000];
    s1_d.atime      = actual_time_i;
    s1_d.stime      = set_time_i;
    s1_d.aq60       = aprod60[K60+13:K60];
    s1_d.sq60       = sprod60[K60+13:K60];
    s1_d.aq3600     = aprod3600[K3600+7:K3600];
    s1_d.sq3600     = sprod3600[K3600+7:K3600];
    s1_d.hm         = set_time_i > sspe_pkg::HM_LIMIT;
    s1_d.ms         = set_time_i > sspe_pkg::MS_LIMIT;
    s1_d.st_zero    = set_time_i == '0;
    s1_d.show_atime = ((actual_time_i != '0) && (set_time_i != '0)) || beep_flash_i;
    s1_d.heat       = heat_icon_on_i;
    s1_d.ticon      = time_icon_on_i;
    s1_d.tblank     = temp_blank_i;
    s1_d.mblank     = time_blank_i;
  end

  // Stage 2: temperature digits, time remainders and format selection.
  always_comb begin
    asec = s1_q.atime - 19'(s1_q.aq60) * 19'd60;
    ssec = s1_q.stime - 19'(s1_q.sq60) * 19'd60;
    amin = s1_q.aq60 - 14'(s1_q.aq3600) * 14'd60;
    smin = s1_q.sq60 - 14'(s1_q.sq3600) * 14'd60;

    s2_d.ad      = temp_digits(s1_q.at, s1_q.at10, s1_q.at100, s1_q.at1000);
    s2_d.sd      = temp_digits(s1_q.st, s1_q.st10, s1_q.st100, s1_q.st1000);
    s2_d.a_show0 = s1_q.at1000 != '0;
    s2_d.a_show1 = s1_q.at100 != '0;
    s2_d.s_show0 = s1_q.st1000 != '0;
    s2_d.s_show1 = s1_q.st100 != '0;
    if (s1_q.hm) begin
      s2_d.ahi = 14'(s1_q.aq3600);
      s2_d.shi = 14'(s1_q.sq3600);
      s2_d.alo = amin[5:0];
      s2_d.slo = smin[5:0];
    end else if (s1_q.ms) begin
      s2_d.ahi = s1_q.aq60;
      s2_d.shi = s1_q.sq60;
      s2_d.alo = asec[5:0];
      s2_d.slo = ssec[5:0];
    end else begin
      s2_d.ahi = '0;
      s2_d.shi = '0;
      s2_d.alo = asec[5:0];
      s2_d.slo = ssec[5:0];
    end
    s2_d.hm         = s1_q.hm;
    s2_d.st_zero    = s1_q.st_zero;
    s2_d.show_atime = s1_q.show_atime;
    s2_d.heat       = s1_q.heat;
    s2_d.ticon      = s1_q.ticon;
    s2_d.tblank     = s1_q.tblank;
    s2_d.mblank     = s1_q.mblank;
  end

  // Stage 3: temperature segment bytes and time quotients by ten.
  always_comb begin
    ahprod = 29'(s2_q.ahi) * 29'(M10);
    shprod = 29'(s2_q.shi) * 29'(M10);
    alprod = 14'(s2_q.alo) * 14'(M10S);
    slprod = 14'(s2_q.slo) * 14'(M10S);

    tb[0] = (s2_q.a_show0 ? sspe_pkg::seg_act(s2_q.ad[0]) : 8'h00) | sspe_pkg::HIGH_BIT;
    tb[1] = s2_q.a_show1 ? sspe_pkg::seg_act(s2_q.ad[1]) : 8'h00;
    tb[2] = sspe_pkg::seg_act(s2_q.ad[2]) | sspe_pkg::HIGH_BIT;
    tb[3] = (sspe_pkg::seg_act(s2_q.ad[3]) & ~sspe_pkg::HIGH_BIT)
          | (s2_q.heat ? 8'h00 : sspe_pkg::HIGH_BIT);
    if (s2_q.tblank) begin
      tb[4] = 8'h00;
      tb[5] = 8'h00;
      tb[6] = 8'h00;
      tb[7] = 8'h00;
    end else begin
      tb[4] = s2_q.s_show0 ? sspe_pkg::seg_set(s2_q.sd[0]) : 8'h00;
      tb[5] = s2_q.s_show1 ? sspe_pkg::seg_set(s2_q.sd[1]) : 8'h00;
      tb[6] = sspe_pkg::seg_set(s2_q.sd[2]);
      tb[7] = sspe_pkg::seg_set(s2_q.sd[3]);
    end
    // The set temperature decimal point stays lit even while blanked.
    tb[6] = tb[6] | sspe_pkg::LOW_BIT;

    s3_d.tb         = tb;
    s3_d.ahi        = s2_q.ahi;
    s3_d.shi        = s2_q.shi;
    s3_d.ahi10      = ahprod[K10+10:K10];
    s3_d.shi10      = shprod[K10+10:K10];
    s3_d.alo        = s2_q.alo;
    s3_d.slo        = s2_q.slo;
    s3_d.alo10      = alprod[K10S+2:K10S];
    s3_d.slo10      = slprod[K10S+2:K10S];
    s3_d.hm         = s2_q.hm;
    s3_d.st_zero    = s2_q.st_zero;
    s3_d.show_atime = s2_q.show_atime;
    s3_d.ticon      = s2_q.ticon;
    s3_d.mblank     = s2_q.mblank;
  end

  // Stage 4: time digits, their segments and the full frame.
  always_comb begin
    atd   = time_digits(s3_q.ahi, s3_q.ahi10, s3_q.alo, s3_q.alo10);
    std_d = time_digits(s3_q.shi, s3_q.shi10, s3_q.slo, s3_q.slo10);
    f4_d  = '0;
    for (int i = 0; i < 4; i++) begin
      f4_d[i]     = s3_q.tb[i];
      f4_d[8 + i] = s3_q.tb[4 + i];
      f4_d[4 + i] = s3_q.show_atime ? sspe_pkg::seg_act(atd[i]) : sspe_pkg::DASH_PATTERN;
      if (s3_q.mblank) begin
        f4_d[16 + i] = 8'h00;
      end else if (s3_q.st_zero) begin
        f4_d[16 + i] = sspe_pkg::DASH_PATTERN;
      end else begin
        f4_d[16 + i] = sspe_pkg::seg_time(std_d[i]);
      end
    end
    f4_d[6]  = (f4_d[6] & ~sspe_pkg::HIGH_BIT) | (s3_q.ticon ? 8'h00 : sspe_pkg::HIGH_BIT);
    f4_d[17] = f4_d[17] | sspe_pkg::HIGH_BIT;
    if (s3_q.hm) begin
      f4_d[19] = f4_d[19] | sspe_pkg::HIGH_BIT;
    end else begin
      f4_d[18] = f4_d[18] | sspe_pkg::HIGH_BIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q <= s1_d;
    end
    if (en2) begin
      s2_q <= s2_d;
    end
    if (en3) begin
      s3_q <= s3_d;
    end
    if (en4) begin
      f4_q <= f4_d;
    end
  end

  assign frame_o.valid = v4_q;
  assign frame_o.bytes = f4_q;

endmodule

[design/sspe_serializer.sv]
// Frame serializer: sends the twenty bytes of a frame one per cycle with their addresses.
module sspe_serializer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sspe_pkg::frame_xfer_t         frame_i,
  output logic                          frame_ready_o,
  output logic                          strobe_o,
  output logic [sspe_pkg::ADDR_W-1:0]   seg_address_o,
  output logic [7:0]                    seg_byte_o,
  output logic                          last_byte_o
);

  // Actual panel runs upward from zero; set panel runs downward from 38.
  localparam logic [sspe_pkg::ADDR_W-1:0] SET_BASE = sspe_pkg::ADDR_W'(54);
  localparam logic [sspe_pkg::CNT_W-1:0]  SET_IDX  = sspe_pkg::CNT_W'(8);

  logic                            active_d, active_q;
  logic [sspe_pkg::CNT_W-1:0]      cnt_d, cnt_q;
  sspe_pkg::frame_t                sh_d, sh_q;
  logic                            load;
  logic [sspe_pkg::ADDR_W-1:0]     addr_d, addr_q;
  logic [sspe_pkg::ADDR_W-1:0]     twice;
  logic                            strobe_q, last_q;
  logic [7:0]                      byte_q;

  assign frame_ready_o = !active_q || (cnt_q == sspe_pkg::LAST_IDX);
  assign load          = frame_i.valid && frame_ready_o;

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    sh_d     = sh_q;
    if (active_q) begin
      sh_d[sspe_pkg::NUM_BYTES-2:0] = sh_q[sspe_pkg::NUM_BYTES-1:1];
      sh_d[sspe_pkg::NUM_BYTES-1]   = 8'h00;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == sspe_pkg::LAST_IDX) begin
        active_d = 1'b0;
      end
    end
    if (load) begin
      sh_d     = frame_i.bytes;
      cnt_d    = '0;
      active_d = 1'b1;
    end
  end

  always_comb begin
    twice  = sspe_pkg::ADDR_W'(cnt_q) << 1;
    addr_d = (cnt_q < SET_IDX) ? twice : (SET_BASE - twice);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
      strobe_q <= active_q;
      last_q   <= active_q && (cnt_q == sspe_pkg::LAST_IDX);
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    addr_q <= addr_d;
    byte_q <= sh_q[0];
  end

  assign strobe_o      = strobe_q;
  assign seg_address_o = addr_q;
  assign seg_byte_o    = byte_q;
  assign last_byte_o   = last_q;

endmodule

[design/seven_segment_panel_encoder.sv]
// Top level of the seven-segment panel encoder: digit pipeline and byte serializer.
//
//   Channel   Handshake        Payload
//   --------  ---------------  ------------------------------------------------------------
//   item in   start_i/busy_o   actual_temp_i, set_temp_i, actual_time_i, set_time_i,
//                              beep_flash_i, heat_icon_on_i, time_icon_on_i,
//                              temp_blank_i, time_blank_i
//   byte out  strobe_o         seg_address_o, seg_byte_o, last_byte_o
//
// An item transfers at a rising edge where start_i is high and busy_o is low.
// Its first byte appears on the output after the pipeline stages, the serializer's shift
// register and its output register; its twenty bytes then follow in consecutive cycles,
// so the sustained rate is set by the serializer's single byte-wide output register.
// Up to four further items are held in the pipeline stages while a frame is being sent;
// busy_o rises only when every stage is full, and a held item is never lost or repeated.
// Reset (rst_ni low, asynchronous) clears all valid bits and the serializer's counter and flags.
// The receiver cannot stall: every strobed byte is taken in the cycle it appears.
module seven_segment_panel_encoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [sspe_pkg::TEMP_W-1:0]   actual_temp_i,
  input  logic [sspe_pkg::TEMP_W-1:0]   set_temp_i,
  input  logic [sspe_pkg::TIME_W-1:0]   actual_time_i,
  input  logic [sspe_pkg::TIME_W-1:0]   set_time_i,
  input  logic                          beep_flash_i,
  input  logic                          heat_icon_on_i,
  input  logic                          time_icon_on_i,
  input  logic                          temp_blank_i,
  input  logic                          time_blank_i,
  output logic                          strobe_o,
  output logic [sspe_pkg::ADDR_W-1:0]   seg_address_o,
  output logic [7:0]                    seg_byte_o,
  output logic                          last_byte_o
);

  // The pipeline's first stage reports whether it can take an item this cycle.
  logic                  pipe_ready;
  logic                  item_xfer;
  sspe_pkg::frame_xfer_t frame;
  logic                  frame_ready;

  assign busy_o    = !pipe_ready;
  assign item_xfer = start_i && pipe_ready;

  // Four register stages: divide by constants, split digits, look up temperature
  // segments, then build the time segments and the complete twenty-byte frame.
  sspe_pipe u_pipe (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (item_xfer),
    .in_ready_o     (pipe_ready),
    .actual_temp_i  (actual_temp_i),
    .set_temp_i     (set_temp_i),
    .actual_time_i  (actual_time_i),
    .set_time_i     (set_time_i),
    .beep_flash_i   (beep_flash_i),
    .heat_icon_on_i (heat_icon_on_i),
    .time_icon_on_i (time_icon_on_i),
    .temp_blank_i   (temp_blank_i),
    .time_blank_i   (time_blank_i),
    .frame_o        (frame),
    .frame_ready_i  (frame_ready)
  );

  // The serializer takes a new frame while it sends the last byte of the previous one,
  // so consecutive items leave with no idle cycle between them.
  sspe_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_i       (frame),
    .frame_ready_o (frame_ready),
    .strobe_o      (strobe_o),
    .seg_address_o (seg_address_o),
    .seg_byte_o    (seg_byte_o),
    .last_byte_o   (last_byte_o)
  );

endmodule

[design/sspe_checker.sv]
// Port-level checker for the seven-segment panel encoder, bound to the top level.
module sspe_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          strobe_o,
  input logic [sspe_pkg::ADDR_W-1:0]   seg_address_o,
  input logic [7:0]                    seg_byte_o,
  input logic                          last_byte_o
);

  // The bytes of one item leave in consecutive cycles.
  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_byte_o |=> strobe_o)
    else $error("byte sequence of an item was interrupted");

  // The final byte of an item goes to the lowest set panel address.
  a_last_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_byte_o |-> seg_address_o == 6'd16)
    else $error("last byte at wrong address");

  // The set panel starts right after the top address of the actual panel.
  a_panel_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && seg_address_o == 6'd38 |-> $past(strobe_o) && $past(seg_address_o) == 6'd14)
    else $error("set panel did not follow the actual panel");

  // An item's first byte follows idle or the last byte of the previous item.
  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && seg_address_o == 6'd0 |-> !$past(strobe_o) || $past(last_byte_o))
    else $error("frame started in the middle of another");

endmodule

bind seven_segment_panel_encoder sspe_checker u_sspe_checker (.*);
